>>> src/rc4d_pkg.sv
package rc4d_pkg;

    // Permutation memory geometry
    localparam int PERM_DEPTH = 256;
    localparam int IDX_W      = 8;

    // Configuration register file
    localparam int KEY_WORDS  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int KLEN_W     = 6;
    localparam int DISC_W     = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCARD = 3'd5;

    // Reset values
    localparam logic [KLEN_W-1:0] DEF_KEY_LEN = 6'd5;
    localparam logic [DISC_W-1:0] DEF_DISCARD = 12'd3072;

    localparam int MAX_KEY_BYTES_DEF = 32;

    // Controller -> datapath commands
    typedef struct packed {
        logic capture;     // latch the incoming data byte
        logic init_start;  // start the identity fill at entry 0
        logic init_wr;     // write S[i] = i, advance i
        logic ksa_start;   // prepare indices for the key schedule
        logic s1;          // step phase 1: read S[i+1], retire pending write
        logic s2;          // step phase 2: update j, read S[j]
        logic s3;          // step phase 3: write S[i], read S[S[i]+S[j]]
        logic add_key;     // key schedule: add key byte into j
        logic clr_ij;      // clear both indices after key schedule
        logic fin_wr;      // retire pending write at end of a byte
        logic out_load;    // load the output register
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic pend;        // a swap write is still waiting
        logic out_free;    // output register can take a new byte
    } t_dp_sts;

endpackage

>>> src/rc4_drop_stream_cipher.sv
// Channel   Handshake                    Payload
// in        i_in_valid / o_in_ready      i_data_byte, i_message_start
// out       o_out_valid / i_out_ready    o_result_byte
// cfg       i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// A byte without message start passes through accept, three memory phases
// (read S[i], read S[j], swap and keystream read) and a finish state.
// A message start adds an identity fill of all 256 entries, a key schedule
// pass over all 256 entries and a discard of discard_count keystream bytes;
// the single-write permutation memory sets the three phases per keystream byte.
// Reset (synchronous, active low) clears indices and control; the
// permutation memory is not cleared. A stalled output holds the finished
// byte; the next transaction is still taken and waits in its finish cycle
// until the output register frees.
module rc4_drop_stream_cipher #(
    parameter int MAX_KEY_BYTES = rc4d_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rc4d_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rc4d_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_message_start,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_result_byte
);
    import rc4d_pkg::*;

    logic [CFG_DATA_W-1:0] r_key [KEY_WORDS];
    logic [KLEN_W-1:0]     r_key_len;
    logic [DISC_W-1:0]     r_discard;
    logic [KEY_WORDS*CFG_DATA_W-1:0] w_key_all;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < KEY_WORDS; w++) begin
                r_key[w] <= '0;
            end
            r_key_len <= DEF_KEY_LEN;
            r_discard <= DEF_DISCARD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx) inside
                [CFG_KEY0:CFG_KEY3]: r_key[i_cfg_idx[1:0]] <= i_cfg_data;
                CFG_KEY_LEN:         r_key_len <= i_cfg_data[KLEN_W-1:0];
                CFG_DISCARD:         r_discard <= i_cfg_data[DISC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_key_all = {r_key[3], r_key[2], r_key[1], r_key[0]};

    rc4d_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_message_start (i_message_start),
        .o_in_ready      (o_in_ready),
        .i_discard_count (r_discard),
        .o_cmd           (w_cmd),
        .i_sts           (w_sts)
    );

    rc4d_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_data_byte   (i_data_byte),
        .i_key         (w_key_all[8*MAX_KEY_BYTES-1:0]),
        .i_key_length  (r_key_len),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_byte (o_result_byte)
    );

endmodule

>>> src/rc4d_datapath.sv
module rc4d_datapath #(
    parameter int MAX_KEY_BYTES = rc4d_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rc4d_pkg::t_dp_cmd             i_cmd,
    output rc4d_pkg::t_dp_sts             o_sts,
    input  logic [7:0]                    i_data_byte,
    input  logic [8*MAX_KEY_BYTES-1:0]    i_key,
    input  logic [rc4d_pkg::KLEN_W-1:0]   i_key_length,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_result_byte
);
    import rc4d_pkg::*;

    localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    // Permutation memory: one write, two registered reads
    logic [IDX_W-1:0] r_perm [PERM_DEPTH];
    logic [IDX_W-1:0] r_rd0;
    logic [IDX_W-1:0] r_rd1;

    // Indices and key position
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [KW-1:0]    r_k;

    // Deferred swap write and read forwarding
    logic             r_pend;
    logic [IDX_W-1:0] r_pend_addr;
    logic [IDX_W-1:0] r_pend_data;
    logic             r_fwd;
    logic [IDX_W-1:0] r_fwd_data;

    // Step operands
    logic [IDX_W-1:0] r_si;
    logic [IDX_W-1:0] r_sj;
    logic [IDX_W-1:0] r_t;
    logic [7:0]       r_data;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;

    logic             w_mem_we;
    logic [IDX_W-1:0] w_wa;
    logic [IDX_W-1:0] w_wd;
    logic [IDX_W-1:0] w_ra0;
    logic [IDX_W-1:0] w_ra1;
    logic [IDX_W-1:0] w_i_inc;
    logic [IDX_W-1:0] w_si;
    logic [7:0]       w_key_byte;
    logic [IDX_W-1:0] w_j_next;
    logic [KLEN_W-1:0] w_len_eff;
    logic [KLEN_W-1:0] w_k_last;
    logic [IDX_W-1:0] w_ks;

    // Effective key length: zero means one, saturate at the maximum
    always_comb begin
        if (i_key_length == '0) begin
            w_len_eff = KLEN_W'(1);
        end else if (i_key_length > KLEN_W'(MAX_KEY_BYTES)) begin
            w_len_eff = KLEN_W'(MAX_KEY_BYTES);
        end else begin
            w_len_eff = i_key_length;
        end
        w_k_last = w_len_eff - KLEN_W'(1);
    end

    // Index arithmetic
    assign w_i_inc    = r_i + 8'd1;
    assign w_si       = r_fwd ? r_fwd_data : r_rd0;
    assign w_key_byte = i_cmd.add_key ? i_key[8*r_k +: 8] : 8'd0;
    assign w_j_next   = r_j + w_si + w_key_byte;
    assign w_ra0      = i_cmd.s1 ? w_i_inc : w_j_next;
    assign w_ra1      = r_si + r_rd0;

    // Keystream byte: patch the read with the swap that was in flight
    always_comb begin
        if (r_t == r_i) begin
            w_ks = r_sj;
        end else if (r_t == r_j) begin
            w_ks = r_si;
        end else begin
            w_ks = r_rd1;
        end
    end

    // Memory write select
    always_comb begin
        w_mem_we = 1'b0;
        w_wa     = r_pend_addr;
        w_wd     = r_pend_data;
        if (i_cmd.init_wr) begin
            w_mem_we = 1'b1;
            w_wa     = r_i;
            w_wd     = r_i;
        end else if (i_cmd.s3) begin
            w_mem_we = 1'b1;
            w_wa     = r_i;
            w_wd     = r_rd0;
        end else if ((i_cmd.s1 || i_cmd.fin_wr) && r_pend) begin
            w_mem_we = 1'b1;
        end
    end

    // Keystream read is held until the output register takes it
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_perm[w_wa] <= w_wd;
        end
        r_rd0 <= r_perm[w_ra0];
        if (i_cmd.s3) begin
            r_rd1 <= r_perm[w_ra1];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.init_start) begin
                r_i <= '0;
            end else if (i_cmd.ksa_start) begin
                r_i <= '1;
            end else if (i_cmd.init_wr || i_cmd.s1) begin
                r_i <= w_i_inc;
            end else if (i_cmd.s3 && i_cmd.clr_ij) begin
                r_i <= '0;
            end

            if (i_cmd.ksa_start || (i_cmd.s3 && i_cmd.clr_ij)) begin
                r_j <= '0;
            end else if (i_cmd.s2) begin
                r_j <= w_j_next;
            end

            if (i_cmd.ksa_start) begin
                r_k <= '0;
            end else if (i_cmd.s2 && i_cmd.add_key) begin
                r_k <= (KLEN_W'(r_k) == w_k_last) ? '0 : r_k + KW'(1);
            end

            if (i_cmd.s3) begin
                r_pend <= 1'b1;
            end else if (i_cmd.s1 || i_cmd.fin_wr) begin
                r_pend <= 1'b0;
            end

            if (i_cmd.s1) begin
                r_fwd <= r_pend && (r_pend_addr == w_i_inc);
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_data <= i_data_byte;
        end
        if (i_cmd.s1) begin
            r_fwd_data <= r_pend_data;
        end
        if (i_cmd.s2) begin
            r_si <= w_si;
        end
        if (i_cmd.s3) begin
            r_pend_addr <= r_j;
            r_pend_data <= r_si;
            r_sj        <= r_rd0;
            r_t         <= w_ra1;
        end
        if (i_cmd.out_load) begin
            r_out_byte <= r_data ^ w_ks;
        end
    end

    assign o_sts.pend     = r_pend;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_result_byte  = r_out_byte;

    // Key position stays inside the active key while scheduling
    a_key_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.s2 && i_cmd.add_key) |-> (KLEN_W'(r_k) < w_len_eff))
        else $error("key position beyond key length");

    // Forwarding only follows a pending swap write
    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fwd) |-> $past(r_pend))
        else $error("forward without pending write");

endmodule

>>> src/rc4d_ctrl.sv
module rc4d_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_message_start,
    output logic                          o_in_ready,
    input  logic [rc4d_pkg::DISC_W-1:0]   i_discard_count,
    output rc4d_pkg::t_dp_cmd             o_cmd,
    input  rc4d_pkg::t_dp_sts             i_sts
);
    import rc4d_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_S1   = 3'd2;
    localparam logic [2:0] ST_S2   = 3'd3;
    localparam logic [2:0] ST_S3   = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam logic [1:0] M_KSA  = 2'd0;
    localparam logic [1:0] M_DROP = 2'd1;
    localparam logic [1:0] M_ENC  = 2'd2;

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_mode,  n_mode;
    logic [DISC_W-1:0] r_cnt,   n_cnt;
    logic              w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Sequencer: fill, key schedule, discard, encrypt
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_message_start) begin
                        o_cmd.init_start = 1'b1;
                        n_cnt            = DISC_W'(PERM_DEPTH - 1);
                        n_state          = ST_INIT;
                    end else begin
                        n_mode  = M_ENC;
                        n_state = ST_S1;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (r_cnt == '0) begin
                    o_cmd.ksa_start = 1'b1;
                    n_mode          = M_KSA;
                    n_cnt           = DISC_W'(PERM_DEPTH - 1);
                    n_state         = ST_S1;
                end else begin
                    n_cnt = r_cnt - DISC_W'(1);
                end
            end
            ST_S1: begin
                o_cmd.s1 = 1'b1;
                n_state  = ST_S2;
            end
            ST_S2: begin
                o_cmd.s2      = 1'b1;
                o_cmd.add_key = (r_mode == M_KSA);
                n_state       = ST_S3;
            end
            ST_S3: begin
                o_cmd.s3 = 1'b1;
                n_state  = ST_S1;
                case (r_mode)
                    M_KSA: begin
                        if (r_cnt == '0) begin
                            o_cmd.clr_ij = 1'b1;
                            if (i_discard_count == '0) begin
                                n_mode = M_ENC;
                            end else begin
                                n_mode = M_DROP;
                                n_cnt  = i_discard_count - DISC_W'(1);
                            end
                        end else begin
                            n_cnt = r_cnt - DISC_W'(1);
                        end
                    end
                    M_DROP: begin
                        if (r_cnt == '0) begin
                            n_mode = M_ENC;
                        end else begin
                            n_cnt = r_cnt - DISC_W'(1);
                        end
                    end
                    default: begin
                        n_state = ST_FIN;
                    end
                endcase
            end
            ST_FIN: begin
                o_cmd.fin_wr = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= M_ENC;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
        end
    end

    // No swap write may be left behind once a byte is finished
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !i_sts.pend)
        else $error("pending swap write while idle");

    // A message start always begins with a full identity fill
    a_start_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_message_start) |=>
            (r_state == ST_INIT) && (r_cnt == DISC_W'(PERM_DEPTH - 1)))
        else $error("message start did not enter fill");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rc4d_pkg::*;

    localparam int     KEY_BYTES_MAX    = MAX_KEY_BYTES_DEF;
    localparam int     MAX_SHOWN        = 10;
    localparam int     RAND_ITEMS       = 1730;
    localparam int     START_BUDGET     = 160;
    localparam int     BIG_PHASE_STARTS = 2;
    localparam int     DRAIN_PAUSE      = 8;
    localparam int     END_PAUSE        = 16;
    localparam longint WATCHDOG_NS      = 64'd20_000_000;

    // Register indexes past the end of the register file; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte;
    logic                  i_message_start;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [7:0]            o_result_byte;

    rc4_drop_stream_cipher i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_message_start (i_message_start),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_byte   (o_result_byte)
    );

    // Cipher state mirror
    logic [7:0]            perm_model [0:PERM_DEPTH-1];
    logic [IDX_W-1:0]      ks_i;
    logic [IDX_W-1:0]      ks_j;
    logic [CFG_DATA_W-1:0] key_model [0:KEY_WORDS-1];
    logic [KLEN_W-1:0]     klen_model;
    logic [DISC_W-1:0]     discard_model;

    // Expected output bytes, oldest first
    logic [7:0] expected_bytes [$];

    int fail_count;
    int result_count;
    bit in_no_idle;
    bit out_no_stall;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(WATCHDOG_NS);
        $display("[rc4_drop_stream_cipher] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void model_reset();
        int n;
        for (n = 0; n < KEY_WORDS; n++) key_model[n] = '0;
        for (n = 0; n < PERM_DEPTH; n++) perm_model[n] = '0;
        klen_model    = DEF_KEY_LEN;
        discard_model = DEF_DISCARD;
        ks_i          = '0;
        ks_j          = '0;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        if (idx <= CFG_KEY3)
            key_model[idx - CFG_KEY0] = data;
        else if (idx == CFG_KEY_LEN)
            klen_model = data[KLEN_W-1:0];
        else if (idx == CFG_DISCARD)
            discard_model = data[DISC_W-1:0];
    endfunction

    function automatic logic [7:0] keystream_next();
        logic [7:0] t;
        logic [7:0] sum;
        ks_i = ks_i + 8'd1;
        ks_j = ks_j + perm_model[ks_i];
        t = perm_model[ks_i];
        perm_model[ks_i] = perm_model[ks_j];
        perm_model[ks_j] = t;
        sum = perm_model[ks_i] + perm_model[ks_j];
        return perm_model[sum];
    endfunction

    // Key schedule: identity fill, then one pass of key mixing
    function automatic void rekey_perm();
        int         len;
        int         n;
        int         kidx;
        logic [7:0] j;
        logic [7:0] kb;
        logic [7:0] t;
        len = int'(klen_model);
        if (len == 0) len = 1;
        if (len > KEY_BYTES_MAX) len = KEY_BYTES_MAX;
        for (n = 0; n < PERM_DEPTH; n++) perm_model[n] = 8'(n);
        j = '0;
        for (n = 0; n < PERM_DEPTH; n++) begin
            kidx = n % len;
            kb = 8'(key_model[kidx / 8] >> ((kidx % 8) * 8));
            j = j + perm_model[n] + kb;
            t = perm_model[n];
            perm_model[n] = perm_model[j];
            perm_model[j] = t;
        end
    endfunction

    function automatic logic [7:0] cipher_byte(input logic [7:0] data, input logic start);
        int n;
        if (start) begin
            rekey_perm();
            ks_i = '0;
            ks_j = '0;
            for (n = 0; n < int'(discard_model); n++) void'(keystream_next());
        end
        return data ^ keystream_next();
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        apply_reg_write(idx, data);
    endtask

    // One input transaction; valid stays up afterwards until the next call or a drain
    task automatic send_byte(input logic [7:0] data, input logic start);
        int gap;
        gap = in_no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= data;
        i_message_start <= start;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        expected_bytes.insert(expected_bytes.size(), cipher_byte(data, start));
    endtask

    // Drop valid, wait for every expected byte, then let the block settle
    task automatic wait_drained(input int pause);
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (pause) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls and checking of each output transaction
    // ------------------------------------------------------------------
    initial begin
        int         stall;
        logic [7:0] exp_b;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = out_no_stall ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            result_count++;
            if (expected_bytes.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("%0t: output %0d unexpected, result_byte=%h",
                             $realtime, result_count, o_result_byte);
            end else begin
                exp_b = expected_bytes.pop_front();
                if (o_result_byte !== exp_b) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("%0t: output %0d result_byte expected %h actual %h",
                                 $realtime, result_count, exp_b, o_result_byte);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers untouched since reset: zero key, length 5, drop 3072
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        wait_drained(DRAIN_PAUSE);
    endtask

    // All-ones key at full length with no drop, then length one with maximum drop
    task automatic test_key_extremes();
        int k;
        for (k = 0; k < KEY_WORDS; k++) write_reg(CFG_KEY0 + 3'(k), '1);
        write_reg(CFG_KEY_LEN, 64'(KEY_BYTES_MAX));
        write_reg(CFG_DISCARD, 64'h0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        wait_drained(DRAIN_PAUSE);
        write_reg(CFG_KEY0, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_KEY_LEN, 64'd1);
        write_reg(CFG_DISCARD, 64'hFFF);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b0);
        wait_drained(DRAIN_PAUSE);
    endtask

    // Length zero acts as one; lengths past the maximum saturate
    task automatic test_key_length_saturation();
        int k;
        for (k = 0; k < KEY_WORDS; k++) write_reg(CFG_KEY0 + 3'(k), {$urandom, $urandom});
        write_reg(CFG_DISCARD, 64'd1);
        write_reg(CFG_KEY_LEN, 64'd0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_drained(DRAIN_PAUSE);
        write_reg(CFG_KEY_LEN, 64'(KEY_BYTES_MAX + 1));
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_drained(DRAIN_PAUSE);
        write_reg(CFG_KEY_LEN, 64'h3F);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_drained(DRAIN_PAUSE);
    endtask

    // New settings inside a message only apply at the next message start;
    // writes to unused indexes change nothing
    task automatic test_write_mid_message();
        int k;
        write_reg(CFG_KEY_LEN, 64'd7);
        write_reg(CFG_DISCARD, 64'd2);
        send_byte(8'h11, 1'b1);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        wait_drained(DRAIN_PAUSE);
        for (k = 0; k < KEY_WORDS; k++) write_reg(CFG_KEY0 + 3'(k), {$urandom, $urandom});
        write_reg(CFG_KEY_LEN, 64'd12);
        write_reg(CFG_DISCARD, 64'd9);
        write_reg(CFG_UNUSED_LO, '1);
        write_reg(CFG_UNUSED_HI, '1);
        send_byte(8'h44, 1'b0);
        send_byte(8'h55, 1'b0);
        wait_drained(DRAIN_PAUSE);
        send_byte(8'h66, 1'b1);
        send_byte(8'h77, 1'b0);
        wait_drained(DRAIN_PAUSE);
    endtask

    // Message starts on consecutive bytes, no idling on either side
    task automatic test_back_to_back_starts();
        in_no_idle   = 1'b1;
        out_no_stall = 1'b1;
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFE, 1'b1);
        wait_drained(DRAIN_PAUSE);
        in_no_idle   = 1'b0;
        out_no_stall = 1'b0;
    endtask

    // Random register settings per phase; each phase is a run of messages
    task automatic configure_random(input bit big);
        int                    k;
        logic [CFG_DATA_W-1:0] wdata;
        for (k = 0; k < KEY_WORDS; k++)
            if ($urandom_range(0, 1) == 1) write_reg(CFG_KEY0 + 3'(k), {$urandom, $urandom});
        wdata = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0)
            wdata[KLEN_W-1:0] = KLEN_W'($urandom_range(1, KEY_BYTES_MAX));
        write_reg(CFG_KEY_LEN, wdata);
        wdata = {$urandom, $urandom};
        if (big) begin
            case ($urandom_range(0, 2))
                0: wdata[DISC_W-1:0] = '1;
                1: wdata[DISC_W-1:0] = DEF_DISCARD;
                default: ;
            endcase
        end else begin
            wdata[DISC_W-1:0] = DISC_W'($urandom_range(0, 31));
        end
        write_reg(CFG_DISCARD, wdata);
        if ($urandom_range(0, 3) == 0)
            write_reg(($urandom_range(0, 1) == 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO,
                      {$urandom, $urandom});
    endtask

    task automatic test_random_traffic();
        int   sent;
        int   phase;
        int   phase_len;
        int   starts_left;
        int   big_starts;
        int   msg_left;
        int   k;
        bit   big;
        bit   want;
        logic st;
        sent        = 0;
        phase       = 0;
        starts_left = START_BUDGET;
        msg_left    = 0;
        while (sent < RAND_ITEMS) begin
            // only a few phases use long drops, to keep the run short
            big = (phase % 9 == 4);
            configure_random(big);
            in_no_idle   = ($urandom_range(0, 3) == 0);
            out_no_stall = ($urandom_range(0, 3) == 0);
            phase_len    = $urandom_range(24, 56);
            big_starts   = 0;
            for (k = 0; k < phase_len; k++) begin
                want = (k == 0) ? ($urandom_range(0, 1) == 1) : (msg_left == 0);
                st = 1'b0;
                if (want && starts_left > 0 && (!big || big_starts < BIG_PHASE_STARTS)) begin
                    st = 1'b1;
                    starts_left--;
                    if (big) big_starts++;
                    msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                           : $urandom_range(4, 32);
                end
                if (msg_left > 0) msg_left--;
                send_byte(8'($urandom_range(0, 255)), st);
            end
            sent += phase_len;
            phase++;
            wait_drained(DRAIN_PAUSE);
        end
        in_no_idle   = 1'b0;
        out_no_stall = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_data_byte     = '0;
        i_message_start = 1'b0;
        fail_count      = 0;
        result_count    = 0;
        in_no_idle      = 1'b0;
        out_no_stall    = 1'b0;
        model_reset();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_key_extremes();
        test_key_length_saturation();
        test_write_mid_message();
        test_back_to_back_starts();
        test_random_traffic();

        wait_drained(END_PAUSE);
        if (fail_count == 0 && expected_bytes.size() == 0) begin
            $display("[rc4_drop_stream_cipher] OK");
        end else begin
            $display("[rc4_drop_stream_cipher] ERROR");
        end
        $finish;
    end

endmodule
